// ===== hdl/pse_pkg.sv =====
// Package for the postfix stack evaluator.
// Holds shared widths, ASCII codes, status and operation codes.
// No dependencies.
package pse_pkg;

    localparam int DATA_W          = 32;
    localparam int SYM_W           = 8;
    localparam int STATUS_W        = 3;
    localparam int ITER_W          = $clog2(DATA_W);
    localparam int STACK_DEPTH_DEF = 128;

    localparam logic [SYM_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] ASCII_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] ASCII_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] ASCII_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] ASCII_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] ASCII_SLASH = 8'h2F;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_INVALID   = 3'd3,
        ST_DIVZERO   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

endpackage

// ===== hdl/pse_sym_if.sv =====
// Input channel of the postfix stack evaluator: one character per transaction.
// Depends on pse_pkg.
interface pse_sym_if;
    import pse_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last_symbol;

    modport source (output valid, symbol, last_symbol, input ready);
    modport sink   (input valid, symbol, last_symbol, output ready);
endinterface

// ===== hdl/pse_res_if.sv =====
// Result channel of the postfix stack evaluator: value and status per transaction.
// Depends on pse_pkg.
interface pse_res_if;
    import pse_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

// ===== hdl/postfix_stack_evaluator.sv =====
// Postfix stack evaluator: digits push, + - * / pop two and push one; result on last char.
// Last state: digit/error/ignored S_IDLE, + - S_EXEC, * S_ITER, / S_FIX via S_DABS, S_ITER.
// Multiply and divide iterate 32 times through the single shared 33-bit adder.
// Result register loads at the finishing edge; input is held off while a result waits.
// Reset (rst_n low, async) empties the stack, clears error and result; stack RAM not cleared.
// Depends on pse_pkg, pse_sym_if, pse_res_if.
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    pse_sym_if.sink  symbols,
    pse_res_if.source results
);
    import pse_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_DABS = 5'b00100,
        S_ITER = 5'b01000,
        S_FIX  = 5'b10000
    } state_t;

    // entries below the top; the top itself lives in tos_reg
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    status_t           err_reg, err_next;
    logic              out_valid_reg, out_valid_next;
    logic [ITER_W-1:0] iter_reg, iter_next;

    logic [DATA_W-1:0] tos_reg, tos_next;
    logic [DATA_W-1:0] wa_reg, wa_next;
    logic [DATA_W-1:0] wb_reg, wb_next;
    logic [DATA_W-1:0] wq_reg, wq_next;
    op_t               op_reg, op_next;
    logic              last_reg, last_next;
    logic              neg_reg, neg_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    status_t           out_status_reg, out_status_next;

    logic [DATA_W-1:0] add_a, add_b;
    logic              add_sub;
    logic [DATA_W:0]   add_sum;

    logic              mem_we;
    logic [CW-1:0]     count_m1, count_m2;
    logic [AW-1:0]     wr_addr, rd_addr;

    logic              accept;
    logic              done_now;
    logic              fin;
    logic [DATA_W-1:0] fin_res;
    logic [DATA_W-1:0] shifted;
    logic [SYM_W-1:0]  sym_off;
    status_t           end_status;

    // shared unit; carry out high on subtract means a >= b
    assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                     + {{DATA_W{1'b0}}, add_sub};

    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);
    assign wr_addr  = count_m1[AW-1:0];
    assign rd_addr  = count_m2[AW-1:0];

    // a result still held blocks input so a finishing item always finds the slot free
    assign symbols.ready  = (state_reg == S_IDLE) && !(out_valid_reg && !results.ready);
    assign accept         = symbols.valid && symbols.ready;
    assign results.valid  = out_valid_reg;
    assign results.value  = $signed(out_value_reg);
    assign results.status = out_status_reg;
    assign sym_off        = symbols.symbol - ASCII_ZERO;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        iter_next       = iter_reg;
        tos_next        = tos_reg;
        wa_next         = wa_reg;
        wb_next         = wb_reg;
        wq_next         = wq_reg;
        op_next         = op_reg;
        last_next       = last_reg;
        neg_next        = neg_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        add_a           = '0;
        add_b           = '0;
        add_sub         = 1'b0;
        mem_we          = 1'b0;
        done_now        = 1'b0;
        fin             = 1'b0;
        fin_res         = '0;
        shifted         = {wa_reg[DATA_W-2:0], wq_reg[DATA_W-1]};
        end_status      = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_now  = 1'b1;
                    last_next = symbols.last_symbol;
                    if (err_reg == ST_OK)
                    begin
                        if (symbols.symbol >= ASCII_ZERO && symbols.symbol <= ASCII_NINE)
                        begin
                            if (count_reg == CW'(STACK_DEPTH))
                            begin
                                err_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                mem_we     = (count_reg != '0);
                                tos_next   = {{(DATA_W-4){1'b0}}, sym_off[3:0]};
                                count_next = count_reg + CW'(1);
                            end
                        end
                        else if (count_reg < CW'(2))
                        begin
                            err_next = ST_UNDERFLOW;
                        end
                        else
                        begin
                            // lhs read issued this edge from rd_addr
                            unique case (symbols.symbol)
                                ASCII_PLUS:
                                begin
                                    op_next    = OP_ADD;
                                    state_next = S_EXEC;
                                    done_now   = 1'b0;
                                end
                                ASCII_MINUS:
                                begin
                                    op_next    = OP_SUB;
                                    state_next = S_EXEC;
                                    done_now   = 1'b0;
                                end
                                ASCII_STAR:
                                begin
                                    op_next    = OP_MUL;
                                    state_next = S_EXEC;
                                    done_now   = 1'b0;
                                end
                                ASCII_SLASH:
                                begin
                                    if (tos_reg == '0)
                                    begin
                                        err_next = ST_DIVZERO;
                                    end
                                    else
                                    begin
                                        op_next    = OP_DIV;
                                        state_next = S_EXEC;
                                        done_now   = 1'b0;
                                    end
                                end
                                default:
                                begin
                                    err_next = ST_INVALID;
                                end
                            endcase
                        end
                    end
                    if (done_now && symbols.last_symbol)
                    begin
                        end_status = err_next;
                        if (err_next == ST_OK && count_next == '0)
                        begin
                            end_status = ST_UNDERFLOW;
                        end
                        out_valid_next  = 1'b1;
                        out_status_next = end_status;
                        out_value_next  = (end_status == ST_OK) ? tos_next : '0;
                        count_next      = '0;
                        err_next        = ST_OK;
                    end
                end
            end
            S_EXEC:
            begin
                unique case (op_reg)
                    OP_ADD:
                    begin
                        add_a   = rd_data_reg;
                        add_b   = tos_reg;
                        fin     = 1'b1;
                        fin_res = add_sum[DATA_W-1:0];
                    end
                    OP_SUB:
                    begin
                        add_a   = rd_data_reg;
                        add_b   = tos_reg;
                        add_sub = 1'b1;
                        fin     = 1'b1;
                        fin_res = add_sum[DATA_W-1:0];
                    end
                    OP_MUL:
                    begin
                        wa_next    = '0;
                        wb_next    = rd_data_reg;
                        wq_next    = tos_reg;
                        iter_next  = '0;
                        state_next = S_ITER;
                    end
                    OP_DIV:
                    begin
                        // dividend magnitude now, divisor magnitude next cycle
                        add_b      = rd_data_reg;
                        add_sub    = 1'b1;
                        wq_next    = rd_data_reg[DATA_W-1] ? add_sum[DATA_W-1:0] : rd_data_reg;
                        wb_next    = tos_reg;
                        neg_next   = rd_data_reg[DATA_W-1] ^ tos_reg[DATA_W-1];
                        state_next = S_DABS;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DABS:
            begin
                add_b      = wb_reg;
                add_sub    = 1'b1;
                wb_next    = wb_reg[DATA_W-1] ? add_sum[DATA_W-1:0] : wb_reg;
                wa_next    = '0;
                iter_next  = '0;
                state_next = S_ITER;
            end
            S_ITER:
            begin
                iter_next = iter_reg + ITER_W'(1);
                if (op_reg == OP_MUL)
                begin
                    // shift-add on the low word
                    add_a   = wa_reg;
                    add_b   = wb_reg;
                    wa_next = wq_reg[0] ? add_sum[DATA_W-1:0] : wa_reg;
                    wb_next = {wb_reg[DATA_W-2:0], 1'b0};
                    wq_next = {1'b0, wq_reg[DATA_W-1:1]};
                    if (iter_reg == ITER_W'(DATA_W - 1))
                    begin
                        fin     = 1'b1;
                        fin_res = wa_next;
                    end
                end
                else
                begin
                    // restoring divide: wa remainder, wq dividend shifting into quotient
                    add_a   = shifted;
                    add_b   = wb_reg;
                    add_sub = 1'b1;
                    wa_next = add_sum[DATA_W] ? add_sum[DATA_W-1:0] : shifted;
                    wq_next = {wq_reg[DATA_W-2:0], add_sum[DATA_W]};
                    if (iter_reg == ITER_W'(DATA_W - 1))
                    begin
                        state_next = S_FIX;
                    end
                end
            end
            S_FIX:
            begin
                add_b   = wq_reg;
                add_sub = 1'b1;
                fin     = 1'b1;
                fin_res = neg_reg ? add_sum[DATA_W-1:0] : wq_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            tos_next   = fin_res;
            count_next = count_m1;
            state_next = S_IDLE;
            if (last_reg)
            begin
                out_valid_next  = 1'b1;
                out_value_next  = fin_res;
                out_status_next = ST_OK;
                count_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            iter_reg      <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg        <= tos_next;
        wa_reg         <= wa_next;
        wb_reg         <= wb_next;
        wq_reg         <= wq_next;
        op_reg         <= op_next;
        last_reg       <= last_next;
        neg_reg        <= neg_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_addr] <= tos_reg;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_busy_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> err_reg == ST_OK && count_reg >= CW'(2))
        else $error("operator in flight with error or short stack");

    a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ST_OK |-> out_value_reg == '0)
        else $error("error result with nonzero value");

    a_iter_op: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ITER || state_reg == S_DABS |-> op_reg == OP_MUL || op_reg == OP_DIV)
        else $error("iteration entered for add or subtract");

endmodule

// ===== sim/pse_result_checker.sv =====
// Result checker for the postfix stack evaluator: tracks accepted characters,
// predicts each expression's value and status, compares against the result channel.
// Depends on pse_pkg, pse_sym_if, pse_res_if.
module pse_result_checker #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    pse_sym_if   sym_ch,
    pse_res_if   res_ch,
    output int   fail_count,
    output int   results_due,
    output int   chars_applied
);
    import pse_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        status_t           status;
    } result_t;

    logic [DATA_W-1:0] operand_mem [STACK_DEPTH];
    int unsigned       stack_level;
    status_t           first_error;
    result_t           expected_q[$];

    initial
    begin
        fail_count    = 0;
        results_due   = 0;
        chars_applied = 0;
    end

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic logic [DATA_W-1:0] abs_val(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? -v : v;
    endfunction

    // One character against the operand stack; sets first_error instead of exiting.
    function automatic void apply_char(input logic [SYM_W-1:0] sym);
        logic [DATA_W-1:0] rhs, lhs, quot, res;
        if (sym >= ASCII_ZERO && sym <= ASCII_NINE)
        begin
            if (stack_level >= STACK_DEPTH)
                first_error = ST_OVERFLOW;
            else
            begin
                operand_mem[stack_level] = DATA_W'(sym - ASCII_ZERO);
                stack_level++;
            end
            return;
        end
        // depth check comes before the character check
        if (stack_level < 2)
        begin
            first_error = ST_UNDERFLOW;
            return;
        end
        rhs = operand_mem[stack_level-1];
        lhs = operand_mem[stack_level-2];
        case (sym)
            ASCII_PLUS:  res = lhs + rhs;
            ASCII_MINUS: res = lhs - rhs;
            ASCII_STAR:  res = lhs * rhs;
            ASCII_SLASH:
            begin
                if (rhs == '0)
                begin
                    first_error = ST_DIVZERO;
                    return;
                end
                // truncate toward zero; min / -1 wraps back to min
                quot = abs_val(lhs) / abs_val(rhs);
                res  = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? -quot : quot;
            end
            default:
            begin
                first_error = ST_INVALID;
                return;
            end
        endcase
        stack_level--;
        operand_mem[stack_level-1] = res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t due;
        if (!rst_n)
        begin
            stack_level = 0;
            first_error = ST_OK;
            expected_q.delete();
        end
        else
        begin
            if (sym_ch.valid && sym_ch.ready)
            begin
                chars_applied++;
                if (first_error == ST_OK)
                begin
                    apply_char(sym_ch.symbol);
                end
                if (sym_ch.last_symbol)
                begin
                    due.status = first_error;
                    due.value  = '0;
                    if (first_error == ST_OK)
                    begin
                        if (stack_level == 0)
                            due.status = ST_UNDERFLOW;
                        else
                            due.value = operand_mem[stack_level-1];
                    end
                    expected_q.push_back(due);
                    stack_level = 0;
                    first_error = ST_OK;
                end
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_q.size() == 0)
                    report($sformatf("result transaction with nothing pending (value %0d status %0d)",
                                     res_ch.value, res_ch.status));
                else
                begin
                    due = expected_q.pop_front();
                    if (res_ch.value !== due.value)
                        report($sformatf("value got %0d expected %0d",
                                         res_ch.value, $signed(due.value)));
                    if (res_ch.status !== due.status)
                        report($sformatf("status got %0d expected %0d",
                                         res_ch.status, due.status));
                end
            end
            results_due = expected_q.size();
        end
    end

endmodule

// ===== sim/postfix_stack_evaluator_test.sv =====
// Top of the postfix stack evaluator testbench: clock, reset, character stimulus,
// result back-pressure and the verdict. Checking lives in pse_result_checker.
// Depends on pse_pkg, pse_sym_if, pse_res_if, postfix_stack_evaluator, pse_result_checker.
module postfix_stack_evaluator_test;
    import pse_pkg::*;

    localparam int DEPTH = STACK_DEPTH_DEF;

    typedef logic [SYM_W-1:0] char_q_t[$];

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   results_due;
    int   chars_applied;

    pse_sym_if sym_ch ();
    pse_res_if res_ch ();

    postfix_stack_evaluator #(.STACK_DEPTH(DEPTH)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .symbols (sym_ch),
        .results (res_ch)
    );

    pse_result_checker #(.STACK_DEPTH(DEPTH)) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .sym_ch        (sym_ch),
        .res_ch        (res_ch),
        .fail_count    (fail_count),
        .results_due   (results_due),
        .chars_applied (chars_applied)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("FAIL postfix_stack_evaluator");
        $finish;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [SYM_W-1:0] digit_char(input int d);
        return ASCII_ZERO + SYM_W'(d);
    endfunction

    function automatic logic [SYM_W-1:0] op_symbol(input op_t op);
        case (op)
            OP_ADD:  return ASCII_PLUS;
            OP_SUB:  return ASCII_MINUS;
            OP_MUL:  return ASCII_STAR;
            default: return ASCII_SLASH;
        endcase
    endfunction

    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic last);
        int gap;
        sym_ch.valid       <= 1'b1;
        sym_ch.symbol      <= sym;
        sym_ch.last_symbol <= last;
        @(posedge clk);
        while (!sym_ch.ready)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            sym_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_expr(input char_q_t text);
        foreach (text[i])
            send_symbol(text[i], i == text.size() - 1);
    endtask

    // Stop offering and wait until every pending result transaction has come back.
    task automatic drain();
        sym_ch.valid <= 1'b0;
        @(posedge clk);
        wait (results_due == 0);
        @(posedge clk);
    endtask

    // Well-formed postfix text with random digits and operators, optionally corrupted.
    task automatic send_formula(input int operands, input int keep, input bit corrupt);
        char_q_t text;
        int      depth, pushed, spot;
        depth  = 0;
        pushed = 0;
        while (pushed < operands || depth > keep)
        begin
            if (pushed < operands && (depth < 2 || $urandom_range(0, 1) == 1))
            begin
                text.push_back(digit_char($urandom_range(0, 9)));
                depth++;
                pushed++;
            end
            else
            begin
                text.push_back(op_symbol(op_t'($urandom_range(0, 3))));
                depth--;
            end
        end
        if (corrupt)
        begin
            spot       = $urandom_range(0, text.size() - 1);
            text[spot] = SYM_W'($urandom_range(0, 255));
        end
        send_expr(text);
    endtask

    // Result side: random stalls, one long hold early on so the block backs up.
    initial
    begin
        int hold;
        int rounds;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        rounds = 0;
        forever
        begin
            rounds++;
            hold = (rounds == 40) ? 600 : pick_gap();
            if (hold > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin
        char_q_t text;
        int      n_expr, pick, extra, cnt;
        rst_n              <= 1'b0;
        sym_ch.valid       <= 1'b0;
        sym_ch.symbol      <= '0;
        sym_ch.last_symbol <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-stack non-digit, extra entries, each operator, division by zero
        // followed by ignored characters, a bad character, negative truncating division
        send_expr('{8'h00});
        send_expr('{digit_char(5), digit_char(9), digit_char(9), ASCII_PLUS});
        send_expr('{digit_char(3), digit_char(7), ASCII_MINUS});
        send_expr('{digit_char(9), digit_char(8), ASCII_STAR});
        send_expr('{digit_char(7), digit_char(0), ASCII_SLASH, digit_char(5), ASCII_PLUS});
        send_expr('{digit_char(1), digit_char(2), 8'hFF});
        send_expr('{digit_char(1), digit_char(8), ASCII_MINUS, digit_char(3), ASCII_SLASH});
        drain();

        n_expr = 0;
        while (chars_applied < 1000)
        begin
            n_expr++;
            pick = $urandom_range(0, 99);
            text.delete();
            if (n_expr == 8 || n_expr == 30 || pick == 99)
            begin
                // fill the stack to one short of the brim, to the brim, or one or three past it
                if (n_expr == 8)
                    extra = 1;
                else if (n_expr == 30)
                    extra = 0;
                else
                begin
                    cnt   = $urandom_range(0, 3);
                    extra = (cnt == 0) ? -1 : (cnt == 3) ? 3 : cnt - 1;
                end
                repeat (DEPTH + extra)
                    text.push_back(digit_char($urandom_range(0, 9)));
                repeat (3)
                    text.push_back(op_symbol(op_t'($urandom_range(0, 3))));
                send_expr(text);
            end
            else if (n_expr == 20 || pick < 2)
            begin
                // 8^10 * 2 wraps to the most negative value, then divide by -1
                text.push_back(digit_char(8));
                repeat (9)
                begin
                    text.push_back(digit_char(8));
                    text.push_back(ASCII_STAR);
                end
                text.push_back(digit_char(2));
                text.push_back(ASCII_STAR);
                text.push_back(digit_char(0));
                text.push_back(digit_char(1));
                text.push_back(ASCII_MINUS);
                text.push_back(ASCII_SLASH);
                send_expr(text);
            end
            else if (pick < 12)
            begin
                cnt = $urandom_range(1, 6);
                repeat (cnt)
                    text.push_back(SYM_W'($urandom_range(0, 255)));
                send_expr(text);
            end
            else
            begin
                cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
                send_formula(cnt, ($urandom_range(0, 6) == 0) ? $urandom_range(2, 3) : 1,
                             pick < 24);
            end
            if (n_expr % 25 == 0)
                drain();
        end

        drain();
        repeat (40) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0)
            $display("PASS postfix_stack_evaluator");
        else
            $display("FAIL postfix_stack_evaluator");
        $finish;
    end

endmodule
